>>> rtl/jrhp_pkg.sv
// Package for the joint reach/hold profiler: shared types, codes and defaults.
// Used by the top level and jrhp_div; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package jrhp_pkg;

  localparam int NumJointsDef = 8;
  localparam int PosWidthDef  = 16;
  localparam int GainWidthDef = 16;

  localparam logic [15:0] ReachTicksRst = 16'd300;
  localparam logic [15:0] RampTicksRst  = 16'd200;
  localparam logic [14:0] FinishThrRst  = 15'd123;

  localparam logic [15:0] KpReachRst = 16'd1920;
  localparam logic [15:0] KdReachRst = 16'd32;
  localparam logic [15:0] KpHoldRst  = 16'd7680;
  localparam logic [15:0] KdHoldRst  = 16'd32;

  localparam logic [16:0] OneQ16 = 17'd65536;

  localparam logic [1:0] OpSample = 2'd0;
  localparam logic [1:0] OpTick   = 2'd1;
  localparam logic [1:0] OpSet    = 2'd2;

  localparam logic [2:0] TabDefPos  = 3'd0;
  localparam logic [2:0] TabKpReach = 3'd1;
  localparam logic [2:0] TabKdReach = 3'd2;
  localparam logic [2:0] TabKpHold  = 3'd3;
  localparam logic [2:0] TabKdHold  = 3'd4;
  localparam logic [2:0] TabTorque  = 3'd5;

  localparam logic [1:0] RegReachTicks = 2'd0;
  localparam logic [1:0] RegRampTicks  = 2'd1;
  localparam logic [1:0] RegFinishThr  = 2'd2;

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_REACH = 2'd1,
    PH_HOLD  = 2'd2
  } jrhp_phase_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQ,
    ST_SM,
    ST_SS,
    ST_MUL,
    ST_ACC,
    ST_EMIT,
    ST_FIN
  } jrhp_state_e;

  typedef struct packed {
    logic        start;
    logic [15:0] num;
    logic [15:0] den;
  } jrhp_div_req_t;

endpackage
`default_nettype wire

>>> rtl/joint_reach_hold_profiler_core.sv
// Joint reach/hold profiler top level: settings, tables, sequencer and ports.
// Depends on jrhp_pkg, jrhp_div and jrhp_mul.
`timescale 1ns / 1ps
`default_nettype none
// A control tick after the first frame produces NUM_JOINTS commands through one
// shared multiplier and a one-bit-per-cycle divider: the ramp fraction and
// smoothstep first (the divider is skipped once the count has reached the
// duration), then one interpolation per joint while reaching and three per joint
// while holding, and a closing state; a stalled output holds each command.
// Input stall stays high for the whole tick.
module joint_reach_hold_profiler_core #(
  parameter int NUM_JOINTS = jrhp_pkg::NumJointsDef,
  parameter int POS_WIDTH  = jrhp_pkg::PosWidthDef,
  parameter int GAIN_WIDTH = jrhp_pkg::GainWidthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [2:0]         joint_sel_i,
  input  wire logic signed [16:0] value_in_i,
  input  wire logic [2:0]         table_sel_i,
  input  wire logic               frame_end_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              joint_out_o,
  output logic signed [15:0]      position_cmd_o,
  output logic [15:0]             stiffness_cmd_o,
  output logic [15:0]             damping_cmd_o,
  output logic signed [15:0]      torque_cmd_o,
  output logic                    phase_out_o,
  output logic                    last_joint_o
);

  localparam int JW  = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int VW0 = (POS_WIDTH > GAIN_WIDTH + 1) ? POS_WIDTH : GAIN_WIDTH + 1;
  localparam int VW  = (VW0 > 16) ? VW0 : 16;
  localparam int BW  = (VW + 1 > 19) ? VW + 1 : 19;
  localparam int PW  = BW + 19;

  // settings
  logic [15:0] reach_ticks_q, ramp_ticks_q;
  logic [14:0] finish_thr_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reach_ticks_q <= jrhp_pkg::ReachTicksRst;
      ramp_ticks_q  <= jrhp_pkg::RampTicksRst;
      finish_thr_q  <= jrhp_pkg::FinishThrRst;
    end else if (wr_en) begin
      case (paddr[3:2])
        jrhp_pkg::RegReachTicks: reach_ticks_q <= pwdata[15:0];
        jrhp_pkg::RegRampTicks:  ramp_ticks_q  <= pwdata[15:0];
        jrhp_pkg::RegFinishThr:  finish_thr_q  <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      jrhp_pkg::RegReachTicks: prdata = {16'd0, reach_ticks_q};
      jrhp_pkg::RegRampTicks:  prdata = {16'd0, ramp_ticks_q};
      jrhp_pkg::RegFinishThr:  prdata = {17'd0, finish_thr_q};
      default:                 prdata = '0;
    endcase
  end

  // saturation helpers
  function automatic logic signed [POS_WIDTH-1:0] sat_pos(logic signed [16:0] v);
    logic signed [33:0] w, hi, lo;
    w  = 34'(v);
    hi = (34'sd1 <<< (POS_WIDTH - 1)) - 34'sd1;
    lo = -hi - 34'sd1;
    if (w > hi) w = hi;
    else if (w < lo) w = lo;
    return POS_WIDTH'(w);
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [16:0] v);
    logic signed [16:0] w;
    w = v;
    if (w > 17'sd32767) w = 17'sd32767;
    else if (w < -17'sd32768) w = -17'sd32768;
    return 16'(w);
  endfunction

  function automatic logic [GAIN_WIDTH-1:0] sat_gain(logic signed [16:0] v);
    logic signed [33:0] w, hi;
    w  = 34'(v);
    hi = (34'sd1 <<< GAIN_WIDTH) - 34'sd1;
    if (w < 34'sd0) w = 34'sd0;
    else if (w > hi) w = hi;
    return GAIN_WIDTH'(w);
  endfunction

  // state
  jrhp_pkg::jrhp_state_e state_q, state_d;
  jrhp_pkg::jrhp_phase_e phase_q;
  logic                  have_frame_q;
  logic [15:0]           reach_cnt_q, ramp_cnt_q;

  logic signed [POS_WIDTH-1:0] meas_q  [NUM_JOINTS];
  logic signed [POS_WIDTH-1:0] start_q [NUM_JOINTS];
  logic signed [15:0]          defp_q  [NUM_JOINTS];
  logic [GAIN_WIDTH-1:0]       kpr_q   [NUM_JOINTS];
  logic [GAIN_WIDTH-1:0]       kdr_q   [NUM_JOINTS];
  logic [GAIN_WIDTH-1:0]       kph_q   [NUM_JOINTS];
  logic [GAIN_WIDTH-1:0]       kdh_q   [NUM_JOINTS];
  logic signed [15:0]          tq_q    [NUM_JOINTS];

  logic        holding_q, full_q, err_q;
  logic [15:0] cnt_q, tk_q;
  logic [16:0] x_q, s_q;
  logic [JW-1:0] j_q;
  logic [1:0]  k_q;
  logic signed [VW:0] res_q [3];

  logic        in_acc, tick_go, sel_ok, last_j, out_free, last_term;
  logic [15:0] cur_cnt, inc_cnt, cur_tk;

  assign in_stall_o = (state_q != jrhp_pkg::ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign sel_ok     = ({1'b0, joint_sel_i} < 4'(NUM_JOINTS));
  assign tick_go    = in_acc && (opcode_i == jrhp_pkg::OpTick) && have_frame_q
                      && (phase_q != jrhp_pkg::PH_WAIT);
  assign cur_cnt    = (phase_q == jrhp_pkg::PH_HOLD) ? ramp_cnt_q : reach_cnt_q;
  assign cur_tk     = (phase_q == jrhp_pkg::PH_HOLD) ? ramp_ticks_q : reach_ticks_q;
  assign inc_cnt    = (cur_cnt == 16'hFFFF) ? cur_cnt : cur_cnt + 16'd1;
  assign last_j     = (j_q == JW'(NUM_JOINTS - 1));
  assign out_free   = ~out_valid_o | ~out_stall_i;
  assign last_term  = holding_q ? (k_q == 2'd2) : (k_q == 2'd0);

  // shared units
  jrhp_pkg::jrhp_div_req_t div_req;
  logic                    div_done;
  logic [15:0]             div_quot;
  logic [17:0]             mul_a;
  logic signed [BW-1:0]    mul_b;
  logic signed [PW-1:0]    prod;

  assign div_req.start = tick_go && (inc_cnt < cur_tk);
  assign div_req.num   = div_req.start ? inc_cnt : cnt_q;
  assign div_req.den   = div_req.start ? cur_tk : tk_q;

  jrhp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  jrhp_mul #(.BW(BW)) u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // interpolation endpoints
  logic signed [VW-1:0] from_v, to_v;
  logic signed [VW:0]   diff_v, lerp_v;
  logic [16:0]          x2;
  logic [18:0]          fac;

  always_comb begin
    from_v = VW'(start_q[j_q]);
    to_v   = VW'(defp_q[j_q]);
    if (holding_q) begin
      case (k_q)
        2'd0: begin
          from_v = VW'($signed({1'b0, kpr_q[j_q]}));
          to_v   = VW'($signed({1'b0, kph_q[j_q]}));
        end
        2'd1: begin
          from_v = VW'($signed({1'b0, kdr_q[j_q]}));
          to_v   = VW'($signed({1'b0, kdh_q[j_q]}));
        end
        default: begin
          from_v = '0;
          to_v   = VW'(tq_q[j_q]);
        end
      endcase
    end
  end

  assign diff_v = (VW+1)'(to_v) - (VW+1)'(from_v);
  assign lerp_v = (VW+1)'(from_v) + (VW+1)'(prod >>> 16);
  assign x2     = prod[32:16];
  assign fac    = 19'd196608 - {1'b0, x_q, 1'b0};

  always_comb begin
    mul_a = {1'b0, s_q};
    mul_b = BW'(diff_v);
    case (state_q)
      jrhp_pkg::ST_SQ: begin
        mul_a = {1'b0, x_q};
        mul_b = BW'($signed({1'b0, x_q}));
      end
      jrhp_pkg::ST_SM: begin
        mul_a = {1'b0, x2};
        mul_b = BW'($signed({1'b0, fac}));
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      jrhp_pkg::ST_IDLE: if (tick_go) state_d = jrhp_pkg::ST_DIV;
      jrhp_pkg::ST_DIV:  if (div_done) state_d = jrhp_pkg::ST_SQ;
      jrhp_pkg::ST_SQ:   state_d = jrhp_pkg::ST_SM;
      jrhp_pkg::ST_SM:   state_d = jrhp_pkg::ST_SS;
      jrhp_pkg::ST_SS:   state_d = jrhp_pkg::ST_MUL;
      jrhp_pkg::ST_MUL:  state_d = jrhp_pkg::ST_ACC;
      jrhp_pkg::ST_ACC:  state_d = last_term ? jrhp_pkg::ST_EMIT : jrhp_pkg::ST_MUL;
      jrhp_pkg::ST_EMIT: begin
        if (out_free) state_d = last_j ? jrhp_pkg::ST_FIN : jrhp_pkg::ST_MUL;
      end
      jrhp_pkg::ST_FIN:  state_d = jrhp_pkg::ST_IDLE;
      default:           state_d = jrhp_pkg::ST_IDLE;
    endcase
  end

  // joint error against the finish threshold
  logic signed [33:0] err_v;
  logic               err_big;

  always_comb begin
    err_v = 34'(defp_q[j_q]) - 34'(meas_q[j_q]);
    if (err_v < 34'sd0) err_v = -err_v;
    err_big = (err_v >= $signed({19'd0, finish_thr_q}));
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= jrhp_pkg::ST_IDLE;
      phase_q      <= jrhp_pkg::PH_WAIT;
      have_frame_q <= 1'b0;
      reach_cnt_q  <= '0;
      ramp_cnt_q   <= '0;
      out_valid_o  <= 1'b0;
      j_q          <= '0;
      k_q          <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc && (opcode_i == jrhp_pkg::OpSample) && frame_end_i) begin
        have_frame_q <= 1'b1;
        if (phase_q == jrhp_pkg::PH_WAIT) begin
          reach_cnt_q <= '0;
          phase_q     <= jrhp_pkg::PH_REACH;
        end
      end
      if (tick_go) begin
        if (phase_q == jrhp_pkg::PH_HOLD) ramp_cnt_q <= inc_cnt;
        else reach_cnt_q <= inc_cnt;
      end
      if (state_q == jrhp_pkg::ST_SS) begin
        j_q <= '0;
        k_q <= '0;
      end
      if ((state_q == jrhp_pkg::ST_ACC) && !last_term) k_q <= k_q + 2'd1;
      if ((state_q == jrhp_pkg::ST_EMIT) && out_free) begin
        j_q <= j_q + JW'(1);
        k_q <= '0;
      end
      if ((state_q == jrhp_pkg::ST_FIN) && !holding_q && (cnt_q >= tk_q) && !err_q) begin
        phase_q    <= jrhp_pkg::PH_HOLD;
        ramp_cnt_q <= '0;
      end
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      if ((state_q == jrhp_pkg::ST_EMIT) && out_free) out_valid_o <= 1'b1;
    end
  end

  // tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_JOINTS; i++) begin
        meas_q[i]  <= '0;
        start_q[i] <= '0;
        defp_q[i]  <= '0;
        kpr_q[i]   <= GAIN_WIDTH'(jrhp_pkg::KpReachRst);
        kdr_q[i]   <= GAIN_WIDTH'(jrhp_pkg::KdReachRst);
        kph_q[i]   <= GAIN_WIDTH'(jrhp_pkg::KpHoldRst);
        kdh_q[i]   <= GAIN_WIDTH'(jrhp_pkg::KdHoldRst);
        tq_q[i]    <= '0;
      end
    end else if (in_acc) begin
      if (opcode_i == jrhp_pkg::OpSample) begin
        for (int i = 0; i < NUM_JOINTS; i++) begin
          if (frame_end_i && (phase_q == jrhp_pkg::PH_WAIT)) begin
            start_q[i] <= (sel_ok && (JW'(joint_sel_i) == JW'(i)))
                          ? sat_pos(value_in_i) : meas_q[i];
          end
        end
        if (sel_ok) meas_q[JW'(joint_sel_i)] <= sat_pos(value_in_i);
      end else if ((opcode_i == jrhp_pkg::OpSet) && sel_ok) begin
        case (table_sel_i)
          jrhp_pkg::TabDefPos:  defp_q[JW'(joint_sel_i)] <= sat16(value_in_i);
          jrhp_pkg::TabKpReach: kpr_q[JW'(joint_sel_i)]  <= sat_gain(value_in_i);
          jrhp_pkg::TabKdReach: kdr_q[JW'(joint_sel_i)]  <= sat_gain(value_in_i);
          jrhp_pkg::TabKpHold:  kph_q[JW'(joint_sel_i)]  <= sat_gain(value_in_i);
          jrhp_pkg::TabKdHold:  kdh_q[JW'(joint_sel_i)]  <= sat_gain(value_in_i);
          jrhp_pkg::TabTorque:  tq_q[JW'(joint_sel_i)]   <= sat16(value_in_i);
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (tick_go) begin
      holding_q <= (phase_q == jrhp_pkg::PH_HOLD);
      full_q    <= (inc_cnt >= cur_tk);
      cnt_q     <= inc_cnt;
      tk_q      <= cur_tk;
      err_q     <= 1'b0;
    end
    if ((state_q == jrhp_pkg::ST_DIV) && div_done) begin
      x_q <= full_q ? jrhp_pkg::OneQ16 : {1'b0, div_quot};
    end
    if (state_q == jrhp_pkg::ST_SS) s_q <= prod[32:16];
    if (state_q == jrhp_pkg::ST_ACC) res_q[k_q] <= lerp_v;
    if ((state_q == jrhp_pkg::ST_EMIT) && out_free) begin
      if (err_big) err_q <= 1'b1;
      joint_out_o    <= 3'(j_q);
      phase_out_o    <= holding_q;
      last_joint_o   <= last_j;
      position_cmd_o <= holding_q ? defp_q[j_q] : 16'(res_q[0]);
      stiffness_cmd_o <= holding_q ? 16'(res_q[0]) : 16'(kpr_q[j_q]);
      damping_cmd_o  <= holding_q ? 16'(res_q[1]) : 16'(kdr_q[j_q]);
      torque_cmd_o   <= holding_q ? 16'(res_q[2]) : 16'sd0;
    end
  end

endmodule
`default_nettype wire

>>> rtl/jrhp_div.sv
// Iterative restoring divider for the ramp fraction: (num << 16) / den, num < den.
// One quotient bit per cycle; depends on jrhp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jrhp_div (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire jrhp_pkg::jrhp_div_req_t req_i,
  output logic                        done_o,
  output logic [15:0]                 quot_o
);

  logic [16:0] rem_q, rem_d;
  logic [15:0] quot_q, quot_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [16:0] rem2;

  always_comb begin
    rem2   = {rem_q[15:0], 1'b0};
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      rem_d  = {1'b0, req_i.num};
      quot_d = '0;
      cnt_d  = 5'd16;
    end else if (cnt_q != 5'd0) begin
      if (rem2 >= {1'b0, req_i.den}) begin
        rem_d  = rem2 - {1'b0, req_i.den};
        quot_d = {quot_q[14:0], 1'b1};
      end else begin
        rem_d  = rem2;
        quot_d = {quot_q[14:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign done_o = (cnt_q == 5'd0);
  assign quot_o = quot_q;

endmodule
`default_nettype wire

>>> rtl/jrhp_mul.sv
// Shared registered multiplier: unsigned 18-bit operand times signed operand.
// Serves smoothstep and every interpolation; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module jrhp_mul #(
  parameter int BW = 19
) (
  input  wire logic                    clk_i,
  input  wire logic [17:0]             a_i,
  input  wire logic signed [BW-1:0]    b_i,
  output logic signed [BW+18:0]        prod_o
);

  always_ff @(posedge clk_i) begin
    prod_o <= $signed({1'b0, a_i}) * b_i;
  end

endmodule
`default_nettype wire

>>> rtl/jrhp_checker.sv
// Port-level checker for the joint reach/hold profiler, with its bind.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
`default_nettype none
module jrhp_checker #(
  parameter int NUM_JOINTS = 8
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        pready,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  joint_out_o,
  input wire logic [15:0] position_cmd_o,
  input wire logic [15:0] torque_cmd_o,
  input wire logic        phase_out_o,
  input wire logic        last_joint_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(position_cmd_o)
      && $stable(joint_out_o))
    else $error("stalled request changed");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_joint_o |-> joint_out_o == 3'(NUM_JOINTS - 1))
    else $error("last joint flag on wrong joint");

  a_reach_tq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !phase_out_o |-> torque_cmd_o == 16'd0)
    else $error("torque during reach");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind joint_reach_hold_profiler_core jrhp_checker #(.NUM_JOINTS(NUM_JOINTS)) u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .pready         (pready),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .joint_out_o    (joint_out_o),
  .position_cmd_o (position_cmd_o),
  .torque_cmd_o   (torque_cmd_o),
  .phase_out_o    (phase_out_o),
  .last_joint_o   (last_joint_o)
);
`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for joint_reach_hold_profiler_core: drives samples, ticks and
// setting writes with random idling, predicts every joint command, and checks the outputs.
// Depends on jrhp_pkg and the profiler RTL.
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic [1:0]         op;
    logic [2:0]         jsel;
    logic signed [16:0] val;
    logic [2:0]         tsel;
    logic               fend;
  } joint_req_t;

  typedef struct {
    logic [2:0]  joint;
    logic [15:0] pos;
    logic [15:0] kp;
    logic [15:0] kd;
    logic [15:0] tq;
    logic        ph;
    logic        last;
  } joint_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode = '0;
  logic [2:0] joint_sel = '0;
  logic signed [16:0] value_in = '0;
  logic [2:0] table_sel = '0;
  logic frame_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] joint_out;
  logic signed [15:0] position_cmd;
  logic [15:0] stiffness_cmd, damping_cmd;
  logic signed [15:0] torque_cmd;
  logic phase_out, last_joint;

  joint_reach_hold_profiler_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .opcode_i(opcode), .joint_sel_i(joint_sel), .value_in_i(value_in),
    .table_sel_i(table_sel), .frame_end_i(frame_end),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .joint_out_o(joint_out), .position_cmd_o(position_cmd),
    .stiffness_cmd_o(stiffness_cmd), .damping_cmd_o(damping_cmd),
    .torque_cmd_o(torque_cmd), .phase_out_o(phase_out), .last_joint_o(last_joint)
  );

  joint_req_t pending_req_q[$];
  joint_cmd_t joint_cmd_q[$];
  int errors = 0;
  bit quiet = 1'b0;
  bit hold_off_req = 1'b0;

  // profiler shadow state
  longint cfg_reach = 300, cfg_ramp = 200, cfg_thr = 123;
  jrhp_pkg::jrhp_phase_e prof_phase = jrhp_pkg::PH_WAIT;
  bit got_frame = 1'b0;
  longint reach_cnt = 0, ramp_cnt = 0;
  longint meas[8], start[8], def_pos[8], kp_r[8], kd_r[8], kp_h[8], kd_h[8], tq_ff[8];
  longint gen_def[8];

  initial begin
    for (int i = 0; i < 8; i++) begin
      meas[i] = 0; start[i] = 0; def_pos[i] = 0; gen_def[i] = 0;
      kp_r[i] = 1920; kd_r[i] = 32; kp_h[i] = 7680; kd_h[i] = 32; tq_ff[i] = 0;
    end
  end

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint smooth_frac(longint cnt, longint ticks);
    longint x, x2;
    x = (ticks == 0) ? 65536 : (cnt * 65536) / ticks;
    if (x > 65536) x = 65536;
    x2 = (x * x) >> 16;
    return (x2 * (196608 - 2 * x)) >> 16;
  endfunction

  function automatic longint blend(longint from, longint to, longint s);
    return from + ((s * (to - from)) >>> 16);
  endfunction

  function automatic void predict_commands(joint_req_t r);
    longint v, s, maxerr, e;
    bit holding;
    joint_cmd_t c;
    v = longint'(r.val);
    if (r.op == jrhp_pkg::OpSample) begin
      meas[r.jsel] = clampl(v, -32768, 32767);
      if (r.fend) begin
        got_frame = 1'b1;
        if (prof_phase == jrhp_pkg::PH_WAIT) begin
          for (int i = 0; i < 8; i++) start[i] = meas[i];
          reach_cnt = 0;
          prof_phase = jrhp_pkg::PH_REACH;
        end
      end
    end else if (r.op == jrhp_pkg::OpSet) begin
      case (r.tsel)
        jrhp_pkg::TabDefPos:  def_pos[r.jsel] = clampl(v, -32768, 32767);
        jrhp_pkg::TabKpReach: kp_r[r.jsel] = clampl(v, 0, 65535);
        jrhp_pkg::TabKdReach: kd_r[r.jsel] = clampl(v, 0, 65535);
        jrhp_pkg::TabKpHold:  kp_h[r.jsel] = clampl(v, 0, 65535);
        jrhp_pkg::TabKdHold:  kd_h[r.jsel] = clampl(v, 0, 65535);
        jrhp_pkg::TabTorque:  tq_ff[r.jsel] = clampl(v, -32768, 32767);
        default: ;
      endcase
    end else if (r.op == jrhp_pkg::OpTick && got_frame && prof_phase != jrhp_pkg::PH_WAIT)
    begin
      holding = (prof_phase == jrhp_pkg::PH_HOLD);
      if (!holding) begin
        if (reach_cnt < 65535) reach_cnt++;
        s = smooth_frac(reach_cnt, cfg_reach);
      end else begin
        if (ramp_cnt < 65535) ramp_cnt++;
        s = smooth_frac(ramp_cnt, cfg_ramp);
      end
      for (int i = 0; i < 8; i++) begin
        c.joint = i[2:0];
        c.ph = holding;
        c.last = (i == 7);
        if (!holding) begin
          c.pos = 16'(blend(start[i], def_pos[i], s));
          c.kp = 16'(kp_r[i]);
          c.kd = 16'(kd_r[i]);
          c.tq = '0;
        end else begin
          c.pos = 16'(def_pos[i]);
          c.kp = 16'(blend(kp_r[i], kp_h[i], s));
          c.kd = 16'(blend(kd_r[i], kd_h[i], s));
          c.tq = 16'(blend(0, tq_ff[i], s));
        end
        joint_cmd_q.push_back(c);
      end
      if (!holding && reach_cnt >= cfg_reach) begin
        maxerr = 0;
        for (int i = 0; i < 8; i++) begin
          e = def_pos[i] - meas[i];
          if (e < 0) e = -e;
          if (e > maxerr) maxerr = e;
        end
        if (maxerr < cfg_thr) begin
          prof_phase = jrhp_pkg::PH_HOLD;
          ramp_cnt = 0;
        end
      end
    end
  endfunction

  // request driver
  int send_gap = 0;
  always @(posedge clk_i) begin
    joint_req_t r;
    logic nxt_valid;
    nxt_valid = in_valid;
    if (in_valid && !in_stall) begin
      predict_commands('{opcode, joint_sel, value_in, table_sel, frame_end});
      nxt_valid = 1'b0;
    end
    if (!nxt_valid && rst_ni) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_req_q.size() > 0) begin
        r = pending_req_q.pop_front();
        opcode <= r.op;
        joint_sel <= r.jsel;
        value_in <= r.val;
        table_sel <= r.tsel;
        frame_end <= r.fend;
        nxt_valid = 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 8);
      end
    end
    in_valid <= nxt_valid;
  end

  // command monitor
  int stall_left = 0;
  bit hold_off_done = 1'b0;
  always @(posedge clk_i) begin
    joint_cmd_t w;
    if (out_valid && !out_stall) begin
      if (joint_cmd_q.size() == 0) begin
        report("unexpected command, joint", joint_out, -1);
      end else begin
        w = joint_cmd_q.pop_front();
        if (joint_out !== w.joint) report("joint", joint_out, w.joint);
        if (position_cmd !== w.pos) report("position", position_cmd, $signed(w.pos));
        if (stiffness_cmd !== w.kp) report("stiffness", stiffness_cmd, w.kp);
        if (damping_cmd !== w.kd) report("damping", damping_cmd, w.kd);
        if (torque_cmd !== w.tq) report("torque", torque_cmd, $signed(w.tq));
        if (phase_out !== w.ph) report("phase", phase_out, w.ph);
        if (last_joint !== w.last) report("last_joint", last_joint, w.last);
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (hold_off_req && !hold_off_done) begin
      hold_off_done = 1'b1;
      stall_left = 300;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic add_req(input logic [1:0] op, input int j, input longint v,
                         input int t, input bit f);
    joint_req_t r;
    r.op = op; r.jsel = j[2:0]; r.val = v[16:0]; r.tsel = t[2:0]; r.fend = f;
    if (op == jrhp_pkg::OpSet && t == jrhp_pkg::TabDefPos)
      gen_def[j[2:0]] = clampl(longint'(r.val), -32768, 32767);
    pending_req_q.push_back(r);
  endtask

  task automatic reg_access(input logic [1:0] idx, input longint v);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= v[31:0];
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== v[31:0]) report("register readback", prdata, v);
    psel <= 1'b0; penable <= 1'b0;
    case (idx)
      jrhp_pkg::RegReachTicks: cfg_reach = v;
      jrhp_pkg::RegRampTicks:  cfg_ramp = v;
      default:                 cfg_thr = v;
    endcase
  endtask

  task automatic drain();
    wait (pending_req_q.size() == 0 && !in_valid && joint_cmd_q.size() == 0);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic random_phase(input int n);
    int added, k;
    added = 0;
    while (added < n) begin
      k = $urandom_range(0, 9);
      if (k <= 3) begin
        for (int j = 0; j < 8; j++)
          add_req(jrhp_pkg::OpSample, j, gen_def[j] + $urandom_range(0, 200) - 100,
                  $urandom_range(0, 7), j == 7);
        added += 8;
      end else if (k <= 6) begin
        repeat ($urandom_range(1, 4)) begin
          add_req(jrhp_pkg::OpTick, $urandom_range(0, 7), $urandom, $urandom_range(0, 7),
                  $urandom);
          added++;
        end
      end else if (k <= 8) begin
        k = $urandom_range(0, 7);
        if (k == jrhp_pkg::TabDefPos && $urandom_range(0, 3) != 0)
          add_req(jrhp_pkg::OpSet, $urandom_range(0, 7), $urandom_range(0, 8192) - 4096, k,
                  $urandom);
        else
          add_req(jrhp_pkg::OpSet, $urandom_range(0, 7), $urandom, k, $urandom);
        added++;
      end else begin
        add_req($urandom_range(0, 3), $urandom_range(0, 7), $urandom, $urandom_range(0, 7),
                $urandom);
        added++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, ignored codes, no commands before the first frame
    add_req(jrhp_pkg::OpTick, 0, 0, 0, 0);
    add_req(2'd3, 1, 65535, 7, 1);
    add_req(jrhp_pkg::OpSet, 0, 65535, jrhp_pkg::TabDefPos, 0);
    add_req(jrhp_pkg::OpSet, 1, -32768, jrhp_pkg::TabDefPos, 0);
    add_req(jrhp_pkg::OpSet, 2, -5, jrhp_pkg::TabKpReach, 0);
    add_req(jrhp_pkg::OpSet, 3, 65535, jrhp_pkg::TabKpHold, 0);
    add_req(jrhp_pkg::OpSet, 3, -32768, jrhp_pkg::TabTorque, 0);
    add_req(jrhp_pkg::OpSet, 4, 40000, jrhp_pkg::TabTorque, 0);
    add_req(jrhp_pkg::OpSet, 5, 777, jrhp_pkg::TabKdReach, 0);
    add_req(jrhp_pkg::OpSet, 6, 65535, jrhp_pkg::TabKdHold, 0);
    add_req(jrhp_pkg::OpSet, 7, 1234, 3'd6, 1);
    add_req(jrhp_pkg::OpSet, 7, 1234, 3'd7, 0);
    add_req(jrhp_pkg::OpSample, 5, 65535, 0, 0);
    add_req(jrhp_pkg::OpSample, 6, -32768, 0, 0);
    add_req(jrhp_pkg::OpSample, 0, 30000, 0, 1);
    add_req(jrhp_pkg::OpTick, 0, 0, 0, 0);
    add_req(jrhp_pkg::OpTick, 0, 0, 0, 0);
    add_req(jrhp_pkg::OpSample, 1, -100, 0, 1);
    add_req(jrhp_pkg::OpTick, 7, -1, 7, 1);
    for (int j = 0; j < 8; j++) add_req(jrhp_pkg::OpSet, j, 0, jrhp_pkg::TabDefPos, 0);
    drain();
    reg_access(jrhp_pkg::RegReachTicks, 1);
    reg_access(jrhp_pkg::RegRampTicks, 1);
    reg_access(jrhp_pkg::RegFinishThr, 32767);
    hold_off_req = 1'b1;
    random_phase(35);
    drain();
    reg_access(jrhp_pkg::RegReachTicks, 65535);
    reg_access(jrhp_pkg::RegRampTicks, 65535);
    reg_access(jrhp_pkg::RegFinishThr, 4);
    random_phase(30);
    drain();
    reg_access(jrhp_pkg::RegReachTicks, 5);
    reg_access(jrhp_pkg::RegRampTicks, 7);
    reg_access(jrhp_pkg::RegFinishThr, 2000);
    random_phase(20);
    wait (pending_req_q.size() == 0);
    quiet = 1'b1;
    random_phase(20);
    wait (pending_req_q.size() == 0 && !in_valid && joint_cmd_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

>>> sim.f
rtl/jrhp_pkg.sv
rtl/jrhp_div.sv
rtl/jrhp_mul.sv
rtl/joint_reach_hold_profiler_core.sv
rtl/jrhp_checker.sv
test/testbench.sv
